// ----- design/fwqm_pkg.sv -----
package fwqm_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned AMT_W    = 32;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned END_W    = 33;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;

  // Serial divider geometry: one quotient bit (window) or two (microseconds) per step.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned USEC_REM_W = 20;
  localparam int unsigned USEC_TRY_W = 22;

  localparam logic [USEC_TRY_W-1:0] USEC_X1 = 22'd1000000;
  localparam logic [USEC_TRY_W-1:0] USEC_X2 = 22'd2000000;
  localparam logic [USEC_TRY_W-1:0] USEC_X3 = 22'd3000000;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd3600;

  // Number of 64-bit usage counters checked directly against their limit.
  localparam logic [STEP_W-1:0] NUM_DIRECT_CHECKS = 5'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_QUERIES      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RESULT_ROWS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RESULT_BYTES = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_READ_ROWS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_READ_BYTES   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EXEC_SECONDS = 4'd7;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD_QUERY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_ERROR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESULT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXEC       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CHECK      = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUERIES      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERRORS       = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RESULT_ROWS  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RESULT_BYTES = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_READ_ROWS    = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_READ_BYTES   = 3'd6;
  localparam logic [STATUS_W-1:0] STATUS_EXEC         = 3'd7;

  // Control for the serial dividers.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ----- design/fwqm_if.sv -----
// Input item channel.
interface fwqm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fwqm_pkg::KIND_W-1:0] kind;
  logic [fwqm_pkg::TIME_W-1:0] now_seconds;
  logic [fwqm_pkg::AMT_W-1:0]  row_count;
  logic [fwqm_pkg::AMT_W-1:0]  byte_count;
  logic [fwqm_pkg::AMT_W-1:0]  exec_micros;

  modport source (
    output valid, kind, now_seconds, row_count, byte_count, exec_micros,
    input  ready
  );
  modport sink (
    input  valid, kind, now_seconds, row_count, byte_count, exec_micros,
    output ready
  );
endinterface

// Result item channel.
interface fwqm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fwqm_pkg::STATUS_W-1:0] status;
  logic [fwqm_pkg::CNT_W-1:0]    used_at_fault;
  logic [fwqm_pkg::END_W-1:0]    window_end;

  modport source (
    output valid, status, used_at_fault, window_end,
    input  ready
  );
  modport sink (
    input  valid, status, used_at_fault, window_end,
    output ready
  );
endinterface

// ----- design/fwqm_rem_div.sv -----
// Restoring divider that yields now mod duration, one quotient bit per step.
module fwqm_rem_div (
  input  logic                        clk_i,
  input  fwqm_pkg::div_ctrl_t         ctrl_i,
  input  logic [fwqm_pkg::TIME_W-1:0] num_i,
  input  logic [fwqm_pkg::TIME_W-1:0] den_i,
  output logic [fwqm_pkg::TIME_W-1:0] rem_o
);

  logic [fwqm_pkg::TIME_W-1:0] num_q;
  logic [fwqm_pkg::TIME_W-1:0] den_q;
  logic [fwqm_pkg::TIME_W-1:0] rem_q;
  logic [fwqm_pkg::TIME_W:0]   trial;
  logic [fwqm_pkg::TIME_W:0]   diff;

  // Bring down the next dividend bit and try one subtraction.
  assign trial = {rem_q, num_q[fwqm_pkg::TIME_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      num_q <= {num_q[fwqm_pkg::TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= diff[fwqm_pkg::TIME_W-1:0];
      end else begin
        rem_q <= trial[fwqm_pkg::TIME_W-1:0];
      end
    end
  end

  assign rem_o = rem_q;

endmodule

// ----- design/fwqm_usec_div.sv -----
// Radix-4 divider of the microsecond counter by one million.
// The quotient digits shift into the dividend register as its bits leave.
module fwqm_usec_div (
  input  logic                       clk_i,
  input  fwqm_pkg::div_ctrl_t        ctrl_i,
  input  logic [fwqm_pkg::CNT_W-1:0] num_i,
  output logic [fwqm_pkg::CNT_W-1:0] quo_o
);

  logic [fwqm_pkg::CNT_W-1:0]      num_q;
  logic [fwqm_pkg::USEC_REM_W-1:0] rem_q;
  logic [fwqm_pkg::USEC_TRY_W-1:0] trial;
  logic [fwqm_pkg::USEC_TRY_W-1:0] rest;
  logic [1:0]                      digit;

  assign trial = {rem_q, num_q[fwqm_pkg::CNT_W-1 -: 2]};

  // Pick the largest multiple of one million that fits.
  always_comb begin
    if (trial >= fwqm_pkg::USEC_X3) begin
      digit = 2'd3;
      rest  = trial - fwqm_pkg::USEC_X3;
    end else if (trial >= fwqm_pkg::USEC_X2) begin
      digit = 2'd2;
      rest  = trial - fwqm_pkg::USEC_X2;
    end else if (trial >= fwqm_pkg::USEC_X1) begin
      digit = 2'd1;
      rest  = trial - fwqm_pkg::USEC_X1;
    end else begin
      digit = 2'd0;
      rest  = trial;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      num_q <= {num_q[fwqm_pkg::CNT_W-3:0], digit};
      rem_q <= rest[fwqm_pkg::USEC_REM_W-1:0];
    end
  end

  assign quo_o = num_q;

endmodule

// ----- design/fixed_window_quota_meter_unit.sv -----
// Fixed-window quota meter.
// Items arrive on in_i (valid/ready); every accepted item yields exactly one
// result on out_o (valid/ready) carrying status, used_at_fault and window_end.
// Limits and the window length go in through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while no item is in flight, and the block
// itself does not enforce this. Unknown indexes are ignored.
// Add-query, add-error and unused kinds go from acceptance through a setup
// state straight to commit. Check kinds (result/read amounts, execution time,
// check only) pass a setup state, 32 steps of the serial dividers (window
// remainder one bit per step, microseconds-to-seconds two bits per step), an
// execution-time check state and a commit state. in_i.ready is high only
// while the meter is idle, so a new item is taken in the cycle after the
// previous commit, never before the previous item has committed.
// The result sits in an output register; the next item can be accepted while
// it waits. If the receiver still stalls when the following result is ready,
// the meter holds in its commit cycle and state stays untouched until then.
// Reset clears all counters and the window start, sets the window length to
// 3600 seconds and all limits to zero (unlimited).
module fixed_window_quota_meter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fwqm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fwqm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fwqm_in_if.sink                         in_i,
  fwqm_out_if.source                      out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [fwqm_pkg::TIME_W-1:0] window_seconds_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_queries_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_errors_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_result_rows_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_result_bytes_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_read_rows_q;
  logic [fwqm_pkg::CNT_W-1:0]  max_read_bytes_q;
  logic [fwqm_pkg::TIME_W-1:0] max_exec_seconds_q;

  // Window state and usage counters.
  logic [fwqm_pkg::TIME_W-1:0] window_start_q;
  logic [fwqm_pkg::CNT_W-1:0]  used_queries_q, used_queries_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_errors_q, used_errors_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_result_rows_q, used_result_rows_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_result_bytes_q, used_result_bytes_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_read_rows_q, used_read_rows_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_read_bytes_q, used_read_bytes_d;
  logic [fwqm_pkg::CNT_W-1:0]  used_exec_micros_q, used_exec_micros_d;

  // Latched item and working registers.
  logic [fwqm_pkg::KIND_W-1:0]   kind_q;
  logic [fwqm_pkg::TIME_W-1:0]   now_q;
  logic [fwqm_pkg::AMT_W-1:0]    rows_q;
  logic [fwqm_pkg::AMT_W-1:0]    bytes_q;
  logic [fwqm_pkg::AMT_W-1:0]    micros_q;
  logic [fwqm_pkg::TIME_W-1:0]   dur_q;
  logic                          realign_q;
  logic [fwqm_pkg::TIME_W-1:0]   start_new_q;
  logic [fwqm_pkg::STEP_W-1:0]   step_q;
  logic [fwqm_pkg::STATUS_W-1:0] stat_q;
  logic [fwqm_pkg::CNT_W-1:0]    amt_q;

  // Output register.
  logic                          out_valid_q;
  logic [fwqm_pkg::STATUS_W-1:0] out_status_q;
  logic [fwqm_pkg::CNT_W-1:0]    out_used_q;
  logic [fwqm_pkg::END_W-1:0]    out_end_q;

  logic                          in_fire;
  logic                          done_fire;
  logic [fwqm_pkg::TIME_W-1:0]   dur_eff;
  logic                          is_check;
  logic                          realign_now;
  fwqm_pkg::div_ctrl_t           div_ctrl;
  logic [fwqm_pkg::TIME_W-1:0]   win_rem;
  logic [fwqm_pkg::CNT_W-1:0]    exec_secs;
  logic [fwqm_pkg::CNT_W-1:0]    sel_lim;
  logic [fwqm_pkg::CNT_W-1:0]    sel_use;
  logic [fwqm_pkg::STATUS_W-1:0] sel_code;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // A zero window length counts as one second.
  assign dur_eff  = (window_seconds_q == '0) ? fwqm_pkg::TIME_W'(1) : window_seconds_q;
  assign is_check = (kind_q >= fwqm_pkg::KIND_RESULT) && (kind_q <= fwqm_pkg::KIND_CHECK);
  assign realign_now = is_check &&
      ({1'b0, now_q} >= ({1'b0, window_start_q} + {1'b0, dur_eff}));

  assign div_ctrl.load = (state_q == S_SETUP);
  assign div_ctrl.step = (state_q == S_RUN);

  fwqm_rem_div u_rem_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (now_q),
    .den_i  (dur_eff),
    .rem_o  (win_rem)
  );

  fwqm_usec_div u_usec_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (used_exec_micros_q),
    .quo_o  (exec_secs)
  );

  // Configuration writes; values are cut to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_seconds_q   <= fwqm_pkg::WINDOW_RESET;
      max_queries_q      <= '0;
      max_errors_q       <= '0;
      max_result_rows_q  <= '0;
      max_result_bytes_q <= '0;
      max_read_rows_q    <= '0;
      max_read_bytes_q   <= '0;
      max_exec_seconds_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fwqm_pkg::REG_WINDOW_SECONDS:   window_seconds_q   <= cfg_data_i[fwqm_pkg::TIME_W-1:0];
        fwqm_pkg::REG_MAX_QUERIES:      max_queries_q      <= cfg_data_i;
        fwqm_pkg::REG_MAX_ERRORS:       max_errors_q       <= cfg_data_i;
        fwqm_pkg::REG_MAX_RESULT_ROWS:  max_result_rows_q  <= cfg_data_i;
        fwqm_pkg::REG_MAX_RESULT_BYTES: max_result_bytes_q <= cfg_data_i;
        fwqm_pkg::REG_MAX_READ_ROWS:    max_read_rows_q    <= cfg_data_i;
        fwqm_pkg::REG_MAX_READ_BYTES:   max_read_bytes_q   <= cfg_data_i;
        fwqm_pkg::REG_MAX_EXEC_SECONDS: max_exec_seconds_q <= cfg_data_i[fwqm_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // One limit is looked at per divider step, in priority order.
  always_comb begin
    case (step_q[2:0])
      3'd0: begin
        sel_lim = max_queries_q; sel_use = used_queries_q;
        sel_code = fwqm_pkg::STATUS_QUERIES;
      end
      3'd1: begin
        sel_lim = max_errors_q; sel_use = used_errors_q;
        sel_code = fwqm_pkg::STATUS_ERRORS;
      end
      3'd2: begin
        sel_lim = max_result_rows_q; sel_use = used_result_rows_q;
        sel_code = fwqm_pkg::STATUS_RESULT_ROWS;
      end
      3'd3: begin
        sel_lim = max_result_bytes_q; sel_use = used_result_bytes_q;
        sel_code = fwqm_pkg::STATUS_RESULT_BYTES;
      end
      3'd4: begin
        sel_lim = max_read_rows_q; sel_use = used_read_rows_q;
        sel_code = fwqm_pkg::STATUS_READ_ROWS;
      end
      3'd5: begin
        sel_lim = max_read_bytes_q; sel_use = used_read_bytes_q;
        sel_code = fwqm_pkg::STATUS_READ_BYTES;
      end
      default: begin
        sel_lim = '0; sel_use = '0;
        sel_code = fwqm_pkg::STATUS_OK;
      end
    endcase
  end

  // Counter updates at commit: clear on realignment, then add this item.
  always_comb begin
    used_queries_d      = used_queries_q;
    used_errors_d       = used_errors_q;
    used_result_rows_d  = used_result_rows_q;
    used_result_bytes_d = used_result_bytes_q;
    used_read_rows_d    = used_read_rows_q;
    used_read_bytes_d   = used_read_bytes_q;
    used_exec_micros_d  = used_exec_micros_q;
    if (realign_q) begin
      used_queries_d      = '0;
      used_errors_d       = '0;
      used_result_rows_d  = '0;
      used_result_bytes_d = '0;
      used_read_rows_d    = '0;
      used_read_bytes_d   = '0;
      used_exec_micros_d  = '0;
    end
    case (kind_q)
      fwqm_pkg::KIND_ADD_QUERY: used_queries_d = used_queries_q + fwqm_pkg::CNT_W'(1);
      fwqm_pkg::KIND_ADD_ERROR: used_errors_d  = used_errors_q + fwqm_pkg::CNT_W'(1);
      fwqm_pkg::KIND_RESULT: begin
        if (stat_q == fwqm_pkg::STATUS_OK) begin
          used_result_rows_d  = used_result_rows_d + fwqm_pkg::CNT_W'(rows_q);
          used_result_bytes_d = used_result_bytes_d + fwqm_pkg::CNT_W'(bytes_q);
        end
      end
      fwqm_pkg::KIND_READ: begin
        if (stat_q == fwqm_pkg::STATUS_OK) begin
          used_read_rows_d  = used_read_rows_d + fwqm_pkg::CNT_W'(rows_q);
          used_read_bytes_d = used_read_bytes_d + fwqm_pkg::CNT_W'(bytes_q);
        end
      end
      fwqm_pkg::KIND_EXEC: begin
        if (stat_q == fwqm_pkg::STATUS_OK) begin
          used_exec_micros_d = used_exec_micros_d + fwqm_pkg::CNT_W'(micros_q);
        end
      end
      default: ;
    endcase
  end

  // Sequencer, working registers and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= S_IDLE;
      window_start_q      <= '0;
      used_queries_q      <= '0;
      used_errors_q       <= '0;
      used_result_rows_q  <= '0;
      used_result_bytes_q <= '0;
      used_read_rows_q    <= '0;
      used_read_bytes_q   <= '0;
      used_exec_micros_q  <= '0;
      realign_q           <= 1'b0;
      dur_q               <= '0;
      start_new_q         <= '0;
      step_q              <= '0;
      stat_q              <= fwqm_pkg::STATUS_OK;
      amt_q               <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      // The output register refills at commit and empties when taken.
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          dur_q       <= dur_eff;
          realign_q   <= realign_now;
          start_new_q <= window_start_q;
          step_q      <= '0;
          stat_q      <= fwqm_pkg::STATUS_OK;
          amt_q       <= '0;
          state_q     <= is_check ? S_RUN : S_DONE;
        end
        S_RUN: begin
          if (!realign_q && (stat_q == fwqm_pkg::STATUS_OK) &&
              (step_q < fwqm_pkg::NUM_DIRECT_CHECKS) &&
              (sel_lim != '0) && (sel_use >= sel_lim)) begin
            stat_q <= sel_code;
            amt_q  <= sel_use;
          end
          step_q <= step_q + fwqm_pkg::STEP_W'(1);
          if (step_q == fwqm_pkg::STEP_W'(fwqm_pkg::DIV_STEPS - 1)) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!realign_q && (stat_q == fwqm_pkg::STATUS_OK) &&
              (max_exec_seconds_q != '0) &&
              (exec_secs >= fwqm_pkg::CNT_W'(max_exec_seconds_q))) begin
            stat_q <= fwqm_pkg::STATUS_EXEC;
            amt_q  <= exec_secs;
          end
          if (realign_q) begin
            start_new_q <= now_q - win_rem;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            window_start_q      <= start_new_q;
            used_queries_q      <= used_queries_d;
            used_errors_q       <= used_errors_d;
            used_result_rows_q  <= used_result_rows_d;
            used_result_bytes_q <= used_result_bytes_d;
            used_read_rows_q    <= used_read_rows_d;
            used_read_bytes_q   <= used_read_bytes_d;
            used_exec_micros_q  <= used_exec_micros_d;
            realign_q           <= 1'b0;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item latch and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= in_i.kind;
      now_q    <= in_i.now_seconds;
      rows_q   <= in_i.row_count;
      bytes_q  <= in_i.byte_count;
      micros_q <= in_i.exec_micros;
    end
    if (done_fire) begin
      out_status_q <= stat_q;
      out_used_q   <= amt_q;
      out_end_q    <= {1'b0, start_new_q} + {1'b0, dur_q};
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.used_at_fault = out_used_q;
  assign out_o.window_end    = out_end_q;

  // A fault always reports a nonzero usage, and an ok result reports none.
  a_fault_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.status == fwqm_pkg::STATUS_OK) == (out_o.used_at_fault == '0)))
    else $error("used_at_fault does not match status");

  // The window end is never below one second.
  a_end_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.window_end != '0))
    else $error("window_end is zero");

  // The execution check only follows the full divider run.
  a_exec_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> ($past(state_q) == S_RUN) &&
                            ($past(step_q) == fwqm_pkg::STEP_W'(fwqm_pkg::DIV_STEPS - 1)))
    else $error("execution check entered early");

  // A realigned window leaves the query and error counters cleared.
  a_realign_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && realign_q) |=> (used_queries_q == '0) && (used_errors_q == '0))
    else $error("counters not cleared on realignment");

  // A realignment never reports a fault.
  a_realign_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && realign_q) |-> (stat_q == fwqm_pkg::STATUS_OK))
    else $error("fault reported in a fresh window");

endmodule
